@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/e2d_pkg.sv @@
`default_nettype none
package e2d_pkg;
  localparam int FieldW = 16;
  localparam int CordW  = 32;
  localparam int Steps  = 30;
  localparam logic signed [CordW-1:0] CordInit = 32'sd652032874;

  typedef logic signed [FieldW-1:0] field_t;

  typedef struct packed {
    field_t roll_angle;
    field_t pitch_angle;
    field_t yaw_angle;
  } in_item_t;

  typedef struct packed {
    field_t dcm_00;
    field_t dcm_01;
    field_t dcm_02;
    field_t dcm_10;
    field_t dcm_11;
    field_t dcm_12;
    field_t dcm_20;
    field_t dcm_21;
    field_t dcm_22;
  } out_item_t;

  function automatic logic signed [CordW-1:0] atan_step(input logic [4:0] i);
    logic signed [CordW-1:0] t;
    begin
      case (i)
        5'd0:  t = 32'sh20000000;
        5'd1:  t = 32'sh12E4051E;
        5'd2:  t = 32'sh09FB385B;
        5'd3:  t = 32'sh051111D4;
        5'd4:  t = 32'sh028B0D43;
        5'd5:  t = 32'sh0145D7E1;
        5'd6:  t = 32'sh00A2F61E;
        5'd7:  t = 32'sh00517C55;
        5'd8:  t = 32'sh0028BE53;
        5'd9:  t = 32'sh00145F2F;
        5'd10: t = 32'sh000A2F98;
        5'd11: t = 32'sh000517CC;
        5'd12: t = 32'sh00028BE6;
        5'd13: t = 32'sh000145F3;
        5'd14: t = 32'sh0000A2FA;
        5'd15: t = 32'sh0000517D;
        5'd16: t = 32'sh000028BE;
        5'd17: t = 32'sh0000145F;
        5'd18: t = 32'sh00000A30;
        5'd19: t = 32'sh00000518;
        5'd20: t = 32'sh0000028C;
        5'd21: t = 32'sh00000146;
        5'd22: t = 32'sh000000A3;
        5'd23: t = 32'sh00000051;
        5'd24: t = 32'sh00000029;
        5'd25: t = 32'sh00000014;
        5'd26: t = 32'sh0000000A;
        5'd27: t = 32'sh00000005;
        5'd28: t = 32'sh00000003;
        5'd29: t = 32'sh00000001;
        default: t = '0;
      endcase
      return t;
    end
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/e2d_in_if.sv @@
`default_nettype none
interface e2d_in_if;
  import e2d_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/e2d_out_if.sv @@
`default_nettype none
interface e2d_out_if;
  import e2d_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/euler_to_dcm.sv @@
`default_nettype none
// Requests pass through the CORDIC (input register, step stages, output
// register), then the matrix stages; one request per cycle unless stalled.
// The whole pipeline advances together; a stall at the output holds every stage.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
module euler_to_dcm #(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst_n,
  e2d_in_if.sink    in_ch,
  e2d_out_if.source out_ch
);
  import e2d_pkg::*;
  localparam int Lat = Steps + 2 + 3;
  localparam int OW  = OUT_FRAC_BITS + 2;

  // Pipeline enable: advance whenever the last stage is empty or drained.
  logic en;
  logic [Lat-1:0] vld_r;
  logic signed [OW-1:0] sph, cph, st, ct, sps, cps;
  out_item_t dcm;

  assign en          = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end

  // One CORDIC per angle, running in lockstep.
  e2d_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_ch.data.roll_angle[ANGLE_BITS-1:0]),
    .sin_q(sph), .cos_q(cph));
  e2d_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_ch.data.pitch_angle[ANGLE_BITS-1:0]),
    .sin_q(st), .cos_q(ct));
  e2d_cordic #(.ANGLE_BITS(ANGLE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_ch.data.yaw_angle[ANGLE_BITS-1:0]),
    .sin_q(sps), .cos_q(cps));

  // Products, triple products and saturated sums.
  e2d_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .sph(sph), .cph(cph), .st(st), .ct(ct),
    .sps(sps), .cps(cps), .dcm(dcm));

  assign out_ch.valid = vld_r[Lat-1];
  assign out_ch.data  = dcm;
endmodule
`default_nettype wire

@@ hw/rtl/e2d_cordic.sv @@
`default_nettype none
// Pipelined rotation-mode CORDIC, one step per stage, stalls on !en.
module e2d_cordic #(
  parameter int ANGLE_BITS    = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [ANGLE_BITS-1:0]    angle,
  output logic signed [OUT_FRAC_BITS+1:0] sin_q,
  output logic signed [OUT_FRAC_BITS+1:0] cos_q
);
  import e2d_pkg::*;
  localparam int Sh = 30 - OUT_FRAC_BITS;
  localparam int OW = OUT_FRAC_BITS + 2;

  logic signed [CordW-1:0] x_r [Steps+1];
  logic signed [CordW-1:0] y_r [Steps+1];
  logic signed [CordW-1:0] z_r [Steps+1];
  logic                    f_r [Steps+1];
  logic signed [OW-1:0]    s_r, c_r;

  logic [CordW-1:0] ph, phf;
  logic             flip;

  always_comb begin
    ph   = {angle, {(CordW-ANGLE_BITS){1'b0}}};
    flip = ph[CordW-1] ^ ph[CordW-2];
    phf  = flip ? (ph + 32'h80000000) : ph;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordInit;
      y_r[0] <= '0;
      z_r[0] <= signed'(phf);
      f_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][CordW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_step(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_step(5'(i));
        end
      end
    end
  end

  function automatic logic signed [OW-1:0] to_out(input logic signed [CordW-1:0] v,
                                                  input logic neg);
    logic signed [CordW+1:0] w, r;
    logic signed [CordW+1:0] one;
    begin
      one = (CordW+2)'(1) <<< OUT_FRAC_BITS;
      w = neg ? -(CordW+2)'(v) : (CordW+2)'(v);
      if (Sh > 0) r = (w + ((CordW+2)'(1) <<< (Sh > 0 ? Sh-1 : 0))) >>> Sh;
      else r = w;
      if (r > one) r = one;
      else if (r < -one) r = -one;
      return r[OW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= to_out(y_r[Steps], f_r[Steps]);
      c_r <= to_out(x_r[Steps], f_r[Steps]);
    end
  end

  assign sin_q = s_r;
  assign cos_q = c_r;
endmodule
`default_nettype wire

@@ hw/rtl/e2d_matrix.sv @@
`default_nettype none
// Three-stage matrix build: pair products, triple products, sums and clamps.
module e2d_matrix #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [OUT_FRAC_BITS+1:0] sph, cph, st, ct, sps, cps,
  output e2d_pkg::out_item_t dcm
);
  import e2d_pkg::*;
  localparam int W  = OUT_FRAC_BITS + 2;
  localparam int PW = 2 * W;

  typedef logic signed [W-1:0] v_t;

  function automatic v_t mq(input v_t a, input v_t b);
    logic signed [PW-1:0] p;
    begin
      p = PW'(a) * PW'(b) + (PW'(1) <<< (OUT_FRAC_BITS-1));
      p = p >>> OUT_FRAC_BITS;
      return p[W-1:0];
    end
  endfunction

  function automatic field_t cl(input logic signed [W:0] v);
    logic signed [W:0] one, r;
    begin
      one = (W+1)'(1) <<< OUT_FRAC_BITS;
      r = v;
      if (r > one) r = one;
      else if (r < -one) r = -one;
      return field_t'(r);
    end
  endfunction

  v_t ctcps_r, ctsps_r, nst_r, sphct_r, cphct_r;
  v_t sphst_r, cphst_r, cphsps_r, cphcps_r, sphsps_r, sphcps_r, cps_r, sps_r;
  v_t a3_r, b3_r, c3_r, d3_r, e3_r, f3_r, g3_r, h3_r, i3_r, j3_r, k3_r, l3_r, m3_r;
  out_item_t dcm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctcps_r  <= mq(ct, cps);
      ctsps_r  <= mq(ct, sps);
      nst_r    <= -st;
      sphct_r  <= mq(sph, ct);
      cphct_r  <= mq(cph, ct);
      sphst_r  <= mq(sph, st);
      cphst_r  <= mq(cph, st);
      cphsps_r <= mq(cph, sps);
      cphcps_r <= mq(cph, cps);
      sphsps_r <= mq(sph, sps);
      sphcps_r <= mq(sph, cps);
      cps_r    <= cps;
      sps_r    <= sps;
      // triple products, pass the rest along
      a3_r <= mq(sphst_r, cps_r);
      b3_r <= mq(sphst_r, sps_r);
      c3_r <= mq(cphst_r, cps_r);
      d3_r <= mq(cphst_r, sps_r);
      e3_r <= cphsps_r;
      f3_r <= cphcps_r;
      g3_r <= sphsps_r;
      h3_r <= sphcps_r;
      i3_r <= ctcps_r;
      j3_r <= ctsps_r;
      k3_r <= nst_r;
      l3_r <= sphct_r;
      m3_r <= cphct_r;
      dcm_r.dcm_00 <= cl((W+1)'(i3_r));
      dcm_r.dcm_01 <= cl((W+1)'(j3_r));
      dcm_r.dcm_02 <= cl((W+1)'(k3_r));
      dcm_r.dcm_10 <= cl((W+1)'(a3_r) - (W+1)'(e3_r));
      dcm_r.dcm_11 <= cl((W+1)'(b3_r) + (W+1)'(f3_r));
      dcm_r.dcm_12 <= cl((W+1)'(l3_r));
      dcm_r.dcm_20 <= cl((W+1)'(c3_r) + (W+1)'(g3_r));
      dcm_r.dcm_21 <= cl((W+1)'(d3_r) - (W+1)'(h3_r));
      dcm_r.dcm_22 <= cl((W+1)'(m3_r));
    end
  end

  assign dcm = dcm_r;
endmodule
`default_nettype wire

@@ hw/rtl/e2d_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module e2d_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic signed [15:0] d00,
  input wire logic signed [15:0] d22
);
  `CHK_IMPL(a_ready_follows_out, clk, rst_n, out_ready, in_ready, "ready lost while output drains")
  `CHK_IMPL(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready, "accepted while stalled")
  `CHK_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_IMPL(a_range, clk, rst_n, out_valid, (d00 <= 16'sd16384) && (d00 >= -16'sd16384) && (d22 <= 16'sd16384) && (d22 >= -16'sd16384), "entry out of range")
endmodule

bind euler_to_dcm e2d_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .d00(out_ch.data.dcm_00), .d22(out_ch.data.dcm_22));
`default_nettype wire
